// File: design/hlg_pkg.sv
// Shared types, register codes and reset constants of the core hotplug load governor.
// No dependencies; every other file of the block imports this package.
package hlg_pkg;

   // Default core count and fixed field widths
   localparam int NUM_CORES_DEF = 4;
   localparam int MASK_W        = 4;
   localparam int CNT_W         = 3;
   localparam int TIME_W        = 32;
   localparam int LOAD_W        = 16;
   localparam int RATE_W        = 32;
   localparam int OP_W          = 2;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_SUSPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_RESUME  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CORES   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CORES   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_UP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_DOWN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_UP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_DOWN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_CORE = 3'd7;

   // Register reset values
   localparam logic [CNT_W-1:0]      MAX_CORES_RST   = 3'd4;
   localparam logic [CNT_W-1:0]      MIN_CORES_RST   = 3'd1;
   localparam logic [LOAD_W-1:0]     LOAD_UP_RST     = 16'd35;
   localparam logic [LOAD_W-1:0]     LOAD_DOWN_RST   = 16'd5;
   localparam logic [CSR_DATA_W-1:0] HOLD_UP_RST     = 16'd90;
   localparam logic [CSR_DATA_W-1:0] HOLD_DOWN_RST   = 16'd450;
   localparam logic [CSR_DATA_W-1:0] PAUSE_RST       = 16'd10000;

   typedef struct packed {
      logic [CNT_W-1:0]      max_cores;
      logic [CNT_W-1:0]      min_cores;
      logic [LOAD_W-1:0]     load_up;
      logic [LOAD_W-1:0]     load_down;
      logic [CSR_DATA_W-1:0] hold_up_ms;
      logic [CSR_DATA_W-1:0] hold_down_ms;
      logic [CSR_DATA_W-1:0] pause_ms;
      logic                  single_core_when_off;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [TIME_W-1:0] now_ms;
      logic [LOAD_W-1:0] load_avg;
      logic [MASK_W-1:0] online_mask;
      logic [RATE_W-1:0] rate_core1;
      logic [RATE_W-1:0] rate_core2;
      logic [RATE_W-1:0] rate_core3;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] start_mask;
      logic [MASK_W-1:0] stop_mask;
      logic              paused;
   } rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0] believed_online;
      logic              pause_flag;
      logic [TIME_W-1:0] pause_deadline;
      logic [TIME_W-1:0] elapsed_ms;
      logic [TIME_W-1:0] previous_ms;
      logic              suspended;
   } state_type;

endpackage

// File: design/hlg_if.sv
// Handshake channels of the core hotplug load governor: request, response, register write.
// Depends on hlg_pkg for field widths.
interface hlg_req_if import hlg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [TIME_W-1:0] now_ms;
   logic [LOAD_W-1:0] load_avg;
   logic [MASK_W-1:0] online_mask;
   logic [RATE_W-1:0] rate_core1;
   logic [RATE_W-1:0] rate_core2;
   logic [RATE_W-1:0] rate_core3;

   modport source (output valid, operation, now_ms, load_avg, online_mask,
                   rate_core1, rate_core2, rate_core3, input ready);
   modport sink   (input valid, operation, now_ms, load_avg, online_mask,
                   rate_core1, rate_core2, rate_core3, output ready);
endinterface

interface hlg_rsp_if import hlg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] start_mask;
   logic [MASK_W-1:0] stop_mask;
   logic              paused;

   modport source (output valid, start_mask, stop_mask, paused, input ready);
   modport sink   (input valid, start_mask, stop_mask, paused, output ready);
endinterface

interface hlg_csr_if import hlg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/core_hotplug_load_governor.sv
// Top level of the core hotplug load governor: input register, governor state,
// result register. Depends on hlg_pkg, hlg_if, hlg_csr and hlg_decide.

// Each request transaction (evaluation tick, suspend or resume) yields exactly one
// response transaction carrying the cores to start, the cores to stop and the pause
// flag. A request is captured in an input register, decided by a single pass of
// comparisons against the governor state and landed in a result register; one request
// is taken every cycle while the response port keeps up, and its result is offered
// on the response port from the result register. Throughput is set only by
// the response handshake: a stalled result holds the decision stage, and the input
// register keeps one more transaction. Register writes are taken at any time with
// ready held high and must only be issued while no transaction is in flight.
module core_hotplug_load_governor import hlg_pkg::*; #(
   parameter int NUM_CORES = NUM_CORES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hlg_req_if.sink   req,
   hlg_rsp_if.source rsp,
   hlg_csr_if.sink   csr
);

   cfg_type   cfg;
   req_type   item_ff;
   logic      item_valid_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   result_in;
   rsp_type   result_ff;
   logic      result_valid_ff;
   logic      advance;
   logic      req_fire;

   // Configuration registers
   assign csr.ready = 1'b1;

   hlg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr.valid),
      .wr_index (csr.index),
      .wr_data  (csr.data),
      .cfg      (cfg)
   );

   // Advance the held transaction when the result register frees up
   assign advance   = item_valid_ff && (!result_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req.ready) begin
         item_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.operation   <= req.operation;
         item_ff.now_ms      <= req.now_ms;
         item_ff.load_avg    <= req.load_avg;
         item_ff.online_mask <= req.online_mask;
         item_ff.rate_core1  <= req.rate_core1;
         item_ff.rate_core2  <= req.rate_core2;
         item_ff.rate_core3  <= req.rate_core3;
      end
   end

   // Decision
   hlg_decide #(.NUM_CORES(NUM_CORES)) u_decide (
      .item   (item_ff),
      .cur    (state_ff),
      .cfg    (cfg),
      .nxt    (state_in),
      .result (result_in)
   );

   // Governor state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.believed_online <= '1;
         state_ff.pause_flag      <= 1'b1;
         state_ff.pause_deadline  <= '0;
         state_ff.elapsed_ms      <= '0;
         state_ff.previous_ms     <= '0;
         state_ff.suspended       <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid      = result_valid_ff;
   assign rsp.start_mask = result_ff.start_mask;
   assign rsp.stop_mask  = result_ff.stop_mask;
   assign rsp.paused     = result_ff.paused;

endmodule

// File: design/hlg_csr.sv
// Configuration register file of the core hotplug load governor.
// Depends on hlg_pkg for register indexes, reset values and cfg_type.
module hlg_csr import hlg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the written index into the matching field
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_MAX_CORES:   cfg_in.max_cores            = wr_data[CNT_W-1:0];
            CSR_MIN_CORES:   cfg_in.min_cores            = wr_data[CNT_W-1:0];
            CSR_LOAD_UP:     cfg_in.load_up              = wr_data[LOAD_W-1:0];
            CSR_LOAD_DOWN:   cfg_in.load_down            = wr_data[LOAD_W-1:0];
            CSR_HOLD_UP:     cfg_in.hold_up_ms           = wr_data;
            CSR_HOLD_DOWN:   cfg_in.hold_down_ms         = wr_data;
            CSR_PAUSE:       cfg_in.pause_ms             = wr_data;
            CSR_SINGLE_CORE: cfg_in.single_core_when_off = wr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_cores            <= MAX_CORES_RST;
         cfg_ff.min_cores            <= MIN_CORES_RST;
         cfg_ff.load_up              <= LOAD_UP_RST;
         cfg_ff.load_down            <= LOAD_DOWN_RST;
         cfg_ff.hold_up_ms           <= HOLD_UP_RST;
         cfg_ff.hold_down_ms         <= HOLD_DOWN_RST;
         cfg_ff.pause_ms             <= PAUSE_RST;
         cfg_ff.single_core_when_off <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/hlg_decide.sv
// Decision logic of the core hotplug load governor: next governor state and result
// for one registered transaction. Depends on hlg_pkg.
module hlg_decide import hlg_pkg::*; #(
   parameter int NUM_CORES = NUM_CORES_DEF
) (
   input  req_type   item,
   input  state_type cur,
   input  cfg_type   cfg,
   output state_type nxt,
   output rsp_type   result
);

   localparam int CORE_W = $clog2(MASK_W);

   logic [MASK_W-1:0]   core_mask;
   logic [MASK_W-1:0]   actual;
   logic [RATE_W-1:0]   rates [MASK_W];
   logic [CNT_W-1:0]    num_online;
   logic [TIME_W:0]     elapsed_sum;
   logic [TIME_W-1:0]   elapsed;
   logic [TIME_W:0]     deadline_sum;
   logic [TIME_W-1:0]   deadline;
   logic [MASK_W-1:0]   believed;
   logic                act;
   logic                want_up;
   logic                want_down;
   logic                up_found;
   logic [CORE_W-1:0]   up_core;
   logic                slow_found;
   logic [CORE_W-1:0]   slow_core;
   logic [RATE_W-1:0]   best_rate;
   logic [MASK_W-1:0]   start_mask;
   logic [MASK_W-1:0]   stop_mask;

   // Mask off cores that do not exist and count the online ones
   always_comb begin
      core_mask  = '0;
      num_online = '0;
      for (int i = 0; i < MASK_W; i++) begin
         core_mask[i] = (i < NUM_CORES);
      end
      actual = item.online_mask & core_mask;
      for (int i = 0; i < MASK_W; i++) begin
         num_online = num_online + CNT_W'(actual[i]);
      end
   end

   assign rates[0] = '0;
   assign rates[1] = item.rate_core1;
   assign rates[2] = item.rate_core2;
   assign rates[3] = item.rate_core3;

   // Saturating elapsed time and pause deadline
   assign elapsed_sum  = {1'b0, cur.elapsed_ms} + {1'b0, item.now_ms - cur.previous_ms};
   assign elapsed      = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
   assign deadline_sum = {1'b0, item.now_ms} + (TIME_W+1)'(cfg.pause_ms);
   assign deadline     = deadline_sum[TIME_W] ? '1 : deadline_sum[TIME_W-1:0];

   // Find the lowest offline core and the slowest online core, both above core 0
   always_comb begin
      up_found   = 1'b0;
      up_core    = '0;
      slow_found = 1'b0;
      slow_core  = CORE_W'(1);
      best_rate  = '0;
      for (int i = 1; i < NUM_CORES; i++) begin
         if (!up_found && !actual[i]) begin
            up_found = 1'b1;
            up_core  = CORE_W'(i);
         end
         if (actual[i] && (!slow_found || rates[i] < best_rate)) begin
            slow_found = 1'b1;
            best_rate  = rates[i];
            slow_core  = CORE_W'(i);
         end
      end
   end

   assign want_up   = (num_online < cfg.max_cores) && (item.load_avg >= cfg.load_up);
   assign want_down = (num_online > cfg.min_cores) && (item.load_avg <= cfg.load_down);

   // Apply the transaction to the governor state
   always_comb begin
      nxt        = cur;
      start_mask = '0;
      stop_mask  = '0;
      believed   = cur.believed_online;
      act        = 1'b1;
      unique case (item.operation)
         OP_TICK: begin
            if (!cur.suspended) begin
               nxt.elapsed_ms  = elapsed;
               nxt.previous_ms = item.now_ms;
               // Hold during the pause, resync the belief once it runs out
               if (cur.pause_flag) begin
                  if (item.now_ms < cur.pause_deadline) begin
                     act = 1'b0;
                  end else begin
                     believed           = actual;
                     nxt.pause_flag     = 1'b0;
                     nxt.pause_deadline = '0;
                  end
               end
               nxt.believed_online = believed;
               if (act) begin
                  priority if (want_up) begin
                     if (elapsed >= TIME_W'(cfg.hold_up_ms) && up_found
                         && !believed[up_core]) begin
                        start_mask[up_core]          = 1'b1;
                        nxt.believed_online[up_core] = 1'b1;
                        nxt.elapsed_ms               = '0;
                     end
                  end else if (want_down) begin
                     if (elapsed >= TIME_W'(cfg.hold_down_ms) && believed[slow_core]) begin
                        if (actual[slow_core]) begin
                           stop_mask[slow_core]           = 1'b1;
                           nxt.believed_online[slow_core] = 1'b0;
                           nxt.elapsed_ms                 = '0;
                        end else begin
                           nxt.pause_deadline = deadline;
                           nxt.pause_flag     = 1'b1;
                        end
                     end
                  end else begin
                     nxt.elapsed_ms = elapsed;
                  end
               end
            end
         end
         OP_SUSPEND: begin
            if (cfg.single_core_when_off) begin
               stop_mask           = actual & ~MASK_W'(1);
               nxt.believed_online = cur.believed_online & ~stop_mask;
            end
            nxt.suspended = 1'b1;
         end
         OP_RESUME: begin
            if (cfg.single_core_when_off) begin
               start_mask          = ~actual & core_mask & ~MASK_W'(1);
               nxt.believed_online = cur.believed_online | start_mask;
            end
            nxt.pause_flag = 1'b1;
            nxt.suspended  = 1'b0;
         end
         default: nxt = cur;
      endcase
   end

   assign result.start_mask = start_mask;
   assign result.stop_mask  = stop_mask;
   assign result.paused     = nxt.pause_flag;

endmodule

// File: bench/core_hotplug_load_governor_test.sv
// Self-checking testbench for the core hotplug load governor: randomized request and
// response handshakes, register phases and an in-order decision predictor.
// Depends on hlg_pkg, the hlg_*_if interfaces and the core_hotplug_load_governor RTL.
module core_hotplug_load_governor_test;
   import hlg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0]   OP_UNUSED        = 2'd3;
   localparam logic [MASK_W-1:0] CORE_BITS        = MASK_W'((1 << NUM_CORES_DEF) - 1);
   localparam logic [MASK_W-1:0] NON_BOOT         = CORE_BITS & ~MASK_W'(1);
   localparam int                NUM_REGS         = 8;
   localparam int                IDLE_PCT         = 35;
   localparam int                RESET_CYCLES     = 8;
   localparam int                SETTLE_CYCLES    = 4;
   localparam int                RANDOM_PER_PHASE = 235;
   localparam int                NUM_PHASES       = 8;
   localparam int                WATCHDOG_LIMIT   = 3000;

   localparam cfg_type CFG_RST = '{max_cores: MAX_CORES_RST, min_cores: MIN_CORES_RST,
                                   load_up: LOAD_UP_RST, load_down: LOAD_DOWN_RST,
                                   hold_up_ms: HOLD_UP_RST, hold_down_ms: HOLD_DOWN_RST,
                                   pause_ms: PAUSE_RST, single_core_when_off: 1'b1};
   localparam state_type ST_RST = '{believed_online: '1, pause_flag: 1'b1,
                                    pause_deadline: '0, elapsed_ms: '0, previous_ms: '0,
                                    suspended: 1'b0};

   logic clock;
   logic reset;

   hlg_req_if req_ch ();
   hlg_rsp_if rsp_ch ();
   hlg_csr_if csr_ch ();

   core_hotplug_load_governor uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Governor state as seen at acceptance, and a look-ahead copy for planning stimulus
   cfg_type           cfg;
   state_type         gov_state;
   state_type         plan_state;
   logic [MASK_W-1:0] plan_online;
   logic [TIME_W-1:0] sim_ms;

   req_type req_backlog [$];
   rsp_type decisions_due [$];

   bit steady = 1'b0;
   bit feeding = 1'b0;
   bit req_fire = 1'b0;
   int mismatches = 0;
   int idle_cycles = 0;

   // Compute one decision and advance the governor state
   function automatic rsp_type govern(inout state_type s, input cfg_type c,
                                      input req_type r);
      rsp_type           res;
      logic [MASK_W-1:0] actual;
      logic [TIME_W-1:0] sum;
      logic [TIME_W-1:0] deadline;
      logic [RATE_W-1:0] rate [NUM_CORES_DEF];
      logic [RATE_W-1:0] best;
      int unsigned       online;
      int                pick;
      int                i;
      logic              found;
      logic              act;
      res = '0;
      actual = r.online_mask & CORE_BITS;
      rate[0] = '0;
      rate[1] = r.rate_core1;
      rate[2] = r.rate_core2;
      rate[3] = r.rate_core3;
      if (r.operation == OP_TICK && !s.suspended) begin
         // Accumulate elapsed time with saturation
         sum = s.elapsed_ms + (r.now_ms - s.previous_ms);
         if (sum < s.elapsed_ms)
            sum = '1;
         s.elapsed_ms = sum;
         s.previous_ms = r.now_ms;
         act = 1'b1;
         // Hold while paused, resync once the deadline has passed
         if (s.pause_flag) begin
            if (r.now_ms < s.pause_deadline) begin
               act = 1'b0;
            end else begin
               s.believed_online = actual;
               s.pause_flag = 1'b0;
               s.pause_deadline = '0;
            end
         end
         if (act) begin
            online = $countones(actual);
            if (online < c.max_cores && r.load_avg >= c.load_up) begin
               // Bring up the lowest offline core
               if (s.elapsed_ms >= c.hold_up_ms) begin
                  pick = NUM_CORES_DEF;
                  for (i = NUM_CORES_DEF - 1; i >= 1; i--)
                     if (!actual[i])
                        pick = i;
                  if (pick < NUM_CORES_DEF && !s.believed_online[pick]) begin
                     res.start_mask[pick] = 1'b1;
                     s.believed_online[pick] = 1'b1;
                     s.elapsed_ms = '0;
                  end
               end
            end else if (online > c.min_cores && r.load_avg <= c.load_down) begin
               // Take down the slowest online non-boot core
               if (s.elapsed_ms >= c.hold_down_ms) begin
                  pick = 1;
                  found = 1'b0;
                  best = '0;
                  for (i = 1; i < NUM_CORES_DEF; i++) begin
                     if (actual[i] && (!found || rate[i] < best)) begin
                        found = 1'b1;
                        best = rate[i];
                        pick = i;
                     end
                  end
                  if (s.believed_online[pick]) begin
                     if (actual[pick]) begin
                        res.stop_mask[pick] = 1'b1;
                        s.believed_online[pick] = 1'b0;
                        s.elapsed_ms = '0;
                     end else begin
                        deadline = r.now_ms + TIME_W'(c.pause_ms);
                        if (deadline < r.now_ms)
                           deadline = '1;
                        s.pause_deadline = deadline;
                        s.pause_flag = 1'b1;
                     end
                  end
               end
            end
         end
      end else if (r.operation == OP_SUSPEND) begin
         if (c.single_core_when_off) begin
            res.stop_mask = actual & NON_BOOT;
            s.believed_online = s.believed_online & ~res.stop_mask;
         end
         s.suspended = 1'b1;
      end else if (r.operation == OP_RESUME) begin
         if (c.single_core_when_off) begin
            res.start_mask = ~actual & NON_BOOT;
            s.believed_online = s.believed_online | res.start_mask;
         end
         s.pause_flag = 1'b1;
         s.suspended = 1'b0;
      end
      res.paused = s.pause_flag;
      return res;
   endfunction

   function automatic req_type request(input logic [OP_W-1:0] op,
                                       input logic [TIME_W-1:0] now,
                                       input logic [LOAD_W-1:0] load,
                                       input logic [MASK_W-1:0] mask,
                                       input logic [RATE_W-1:0] r1,
                                       input logic [RATE_W-1:0] r2,
                                       input logic [RATE_W-1:0] r3);
      return '{operation: op, now_ms: now, load_avg: load, online_mask: mask,
               rate_core1: r1, rate_core2: r2, rate_core3: r3};
   endfunction

   // Queue a transaction and let the platform follow the planned decision
   task automatic queue_item(input req_type r);
      rsp_type plan;
      req_backlog.push_back(r);
      plan = govern(plan_state, cfg, r);
      plan_online = (r.online_mask | plan.start_mask) & ~plan.stop_mask;
   endtask

   // Random transactions that mostly track the platform, with noise on time and mask
   task automatic plan_phase(input int count);
      req_type           r;
      logic [RATE_W-1:0] rv;
      int                made;
      int                roll;
      int                lv;
      int                k;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(99);
         if (plan_state.suspended)
            r.operation = (roll < 35) ? OP_RESUME : (roll < 40) ? OP_SUSPEND : OP_TICK;
         else
            r.operation = (roll < 3) ? OP_SUSPEND : (roll < 7) ? OP_RESUME :
                          (roll < 8) ? OP_UNUSED : OP_TICK;

         roll = $urandom_range(99);
         if (roll < 85)
            sim_ms = sim_ms + $urandom_range(300);
         else if (roll < 93)
            sim_ms = sim_ms + $urandom_range(20000);
         else if (roll < 97)
            sim_ms = $urandom;
         else
            sim_ms = sim_ms + $urandom;
         r.now_ms = sim_ms;

         roll = $urandom_range(99);
         if (roll < 40) begin
            lv = int'(cfg.load_up) + int'($urandom_range(40));
            if (lv > 65535)
               lv = 65535;
         end else if (roll < 80) begin
            lv = int'(cfg.load_down) - int'($urandom_range(40));
            if (lv < 0)
               lv = 0;
         end else begin
            lv = $urandom_range(65535);
         end
         r.load_avg = lv[LOAD_W-1:0];

         roll = $urandom_range(99);
         if (roll < 7)
            plan_online = plan_online ^ MASK_W'(1 << $urandom_range(NUM_CORES_DEF - 1));
         else if (roll < 10)
            plan_online = MASK_W'($urandom_range(15));
         r.online_mask = plan_online;

         // Favor a few small rates so ties happen
         for (k = 1; k < NUM_CORES_DEF; k++) begin
            rv = $urandom;
            if ($urandom_range(9) < 4)
               rv = (rv[1:0] == 2'b11) ? '1 : RATE_W'(rv[1:0]);
            case (k)
               1: r.rate_core1 = rv;
               2: r.rate_core2 = rv;
               default: r.rate_core3 = rv;
            endcase
         end

         if (!(r.operation == OP_UNUSED || (r.operation == OP_TICK && plan_state.suspended)))
            made++;
         queue_item(r);
      end
   endtask

   // Write every register, then mirror the new setting
   task automatic program_regs(input cfg_type nc);
      logic [CSR_DATA_W-1:0] vals [NUM_REGS];
      int                    k;
      vals[CSR_MAX_CORES]   = CSR_DATA_W'(nc.max_cores);
      vals[CSR_MIN_CORES]   = CSR_DATA_W'(nc.min_cores);
      vals[CSR_LOAD_UP]     = nc.load_up;
      vals[CSR_LOAD_DOWN]   = nc.load_down;
      vals[CSR_HOLD_UP]     = nc.hold_up_ms;
      vals[CSR_HOLD_DOWN]   = nc.hold_down_ms;
      vals[CSR_PAUSE]       = nc.pause_ms;
      vals[CSR_SINGLE_CORE] = CSR_DATA_W'(nc.single_core_when_off);
      for (k = 0; k < NUM_REGS; k++) begin
         @(negedge clock);
         csr_ch.valid <= 1'b1;
         csr_ch.index <= CSR_IDX_W'(k);
         csr_ch.data  <= vals[k];
         do @(posedge clock); while (!csr_ch.ready);
      end
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      cfg = nc;
   endtask

   // Hold until every queued transaction has been answered
   task automatic wait_idle();
      while (req_backlog.size() != 0 || feeding || decisions_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: clear during reset, advance on acceptance, idle at random
   always @(negedge clock) begin
      req_type nxt;
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.operation   <= OP_TICK;
         req_ch.now_ms      <= '0;
         req_ch.load_avg    <= '0;
         req_ch.online_mask <= '0;
         req_ch.rate_core1  <= '0;
         req_ch.rate_core2  <= '0;
         req_ch.rate_core3  <= '0;
         feeding = 1'b0;
      end else if (!feeding || req_fire) begin
         if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = req_backlog.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.operation   <= nxt.operation;
            req_ch.now_ms      <= nxt.now_ms;
            req_ch.load_avg    <= nxt.load_avg;
            req_ch.online_mask <= nxt.online_mask;
            req_ch.rate_core1  <= nxt.rate_core1;
            req_ch.rate_core2  <= nxt.rate_core2;
            req_ch.rate_core3  <= nxt.rate_core3;
            feeding = 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
            feeding = 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      req_type seen;
      rsp_type want;
      if (reset) begin
         req_fire = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fire = req_ch.valid && req_ch.ready;
         if (req_fire) begin
            seen = '{operation: req_ch.operation, now_ms: req_ch.now_ms,
                     load_avg: req_ch.load_avg, online_mask: req_ch.online_mask,
                     rate_core1: req_ch.rate_core1, rate_core2: req_ch.rate_core2,
                     rate_core3: req_ch.rate_core3};
            decisions_due.push_back(govern(gov_state, cfg, seen));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (decisions_due.size() == 0) begin
               $display("%0t: response with no transaction outstanding: start %h stop %h paused %b",
                        $time, rsp_ch.start_mask, rsp_ch.stop_mask, rsp_ch.paused);
               mismatches++;
            end else begin
               want = decisions_due.pop_front();
               if (rsp_ch.start_mask !== want.start_mask) begin
                  $display("%0t: start_mask expected %h actual %h",
                           $time, want.start_mask, rsp_ch.start_mask);
                  mismatches++;
               end
               if (rsp_ch.stop_mask !== want.stop_mask) begin
                  $display("%0t: stop_mask expected %h actual %h",
                           $time, want.stop_mask, rsp_ch.stop_mask);
                  mismatches++;
               end
               if (rsp_ch.paused !== want.paused) begin
                  $display("%0t: paused expected %b actual %b",
                           $time, want.paused, rsp_ch.paused);
                  mismatches++;
               end
            end
         end
         // Watchdog on cycles without any transaction
         if (req_fire || (rsp_ch.valid && rsp_ch.ready) || (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Stimulus sequencer
   initial begin
      int      p;
      cfg_type nc;
      reset              <= 1'b1;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_MAX_CORES;
      csr_ch.data        <= '0;
      cfg = CFG_RST;
      gov_state = ST_RST;
      plan_state = ST_RST;
      plan_online = CORE_BITS;
      sim_ms = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default limits: resync, add, remove with rate ties, suspend and resume,
      // unused operation, time extremes
      program_regs(CFG_RST);
      queue_item(request(OP_TICK, 0, 0, 4'hF, 0, 0, 0));
      queue_item(request(OP_TICK, 500, 0, 4'hF, 5, 5, 9));
      queue_item(request(OP_TICK, 1000, 0, 4'hF, 1, 7, 7));
      queue_item(request(OP_TICK, 1100, 35, 4'b1101, '1, '1, '1));
      queue_item(request(OP_TICK, 1400, 40, 4'b1011, 0, 0, 0));
      queue_item(request(OP_TICK, 2000, 5, 4'hF, '1, '1, '1));
      queue_item(request(OP_SUSPEND, 2100, 0, 4'hF, 0, 0, 0));
      queue_item(request(OP_TICK, 2200, 16'hFFFF, 4'b0001, 0, 0, 0));
      queue_item(request(OP_SUSPEND, 2300, 0, 4'b0011, 0, 0, 0));
      queue_item(request(OP_UNUSED, 2400, 16'hFFFF, 4'hF, '1, '1, '1));
      queue_item(request(OP_RESUME, 2500, 0, 4'b0001, 0, 0, 0));
      queue_item(request(OP_TICK, 2600, 0, 4'hF, 0, 0, 0));
      queue_item(request(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 4'h0, '1, '1, '1));
      queue_item(request(OP_TICK, 32'h8000_0000, 0, 4'hF, 3, 2, 1));
      wait_idle();

      // No floor on cores: mismatch pause, saturated deadline, suspend without stops
      nc = '{max_cores: 3'd4, min_cores: 3'd0, load_up: 16'd40, load_down: 16'd5,
             hold_up_ms: 16'd0, hold_down_ms: 16'd0, pause_ms: 16'hFFFF,
             single_core_when_off: 1'b0};
      program_regs(nc);
      queue_item(request(OP_RESUME, 100, 0, 4'hF, 0, 0, 0));
      queue_item(request(OP_TICK, 200, 100, 4'hF, 0, 0, 0));
      queue_item(request(OP_TICK, 300, 0, 4'b0001, 0, 0, 0));
      queue_item(request(OP_TICK, 400, 0, 4'b0001, 0, 0, 0));
      queue_item(request(OP_TICK, 65835, 0, 4'b0001, 0, 0, 0));
      queue_item(request(OP_TICK, 65900, 40, 4'b0001, 0, 0, 0));
      queue_item(request(OP_TICK, 32'hFFFF_FFF0, 0, 4'b0001, 0, 0, 0));
      queue_item(request(OP_TICK, 32'hFFFF_FFFE, 0, 4'hF, 0, 0, 0));
      queue_item(request(OP_TICK, 32'hFFFF_FFFF, 0, 4'hF, 0, 0, 0));
      queue_item(request(OP_SUSPEND, 0, 0, 4'hF, 0, 0, 0));
      queue_item(request(OP_RESUME, 10, 0, 4'b0001, 0, 0, 0));
      sim_ms = 10;
      wait_idle();

      // Random phases, each under its own setting
      for (p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: nc = CFG_RST;
            1: nc = '{max_cores: 3'd4, min_cores: 3'd0, load_up: 16'd20, load_down: 16'd10,
                      hold_up_ms: 16'd0, hold_down_ms: 16'd0, pause_ms: 16'd50,
                      single_core_when_off: 1'b1};
            2: nc = '{max_cores: 3'd7, min_cores: 3'd5, load_up: 16'd0, load_down: 16'd0,
                      hold_up_ms: 16'hFFFF, hold_down_ms: 16'd0, pause_ms: 16'd0,
                      single_core_when_off: 1'b1};
            3: nc = '{max_cores: 3'd0, min_cores: 3'd0, load_up: 16'hFFFF,
                      load_down: 16'hFFFF, hold_up_ms: 16'd0, hold_down_ms: 16'd100,
                      pause_ms: 16'hFFFF, single_core_when_off: 1'b0};
            4: nc = '{max_cores: 3'd3, min_cores: 3'd2, load_up: 16'd100, load_down: 16'd50,
                      hold_up_ms: 16'd200, hold_down_ms: 16'd300, pause_ms: 16'd1000,
                      single_core_when_off: 1'b1};
            default: begin
               nc.max_cores            = CNT_W'($urandom_range(1, 4));
               nc.min_cores            = CNT_W'($urandom_range(0, 4));
               nc.load_up              = LOAD_W'($urandom_range(200));
               nc.load_down            = LOAD_W'($urandom_range(100));
               nc.hold_up_ms           = CSR_DATA_W'($urandom_range(600));
               nc.hold_down_ms         = CSR_DATA_W'($urandom_range(900));
               nc.pause_ms             = CSR_DATA_W'($urandom_range(3000));
               nc.single_core_when_off = 1'($urandom_range(1));
            end
         endcase
         program_regs(nc);
         steady = (p == 2);
         plan_phase(RANDOM_PER_PHASE);
         wait_idle();
      end
      steady = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: core_hotplug_load_governor.f
design/hlg_pkg.sv
design/hlg_if.sv
design/hlg_csr.sv
design/hlg_decide.sv
design/core_hotplug_load_governor.sv
bench/core_hotplug_load_governor_test.sv
